// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHECK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication checked with the consequent on the next clock edge.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/sfm_pkg.sv
// Package: types and constants of the sector flash store.
package sfm_pkg;
  localparam int DefSectorCount = 16;
  localparam int DefWindowCount = 2;
  localparam int PagesPerSector = 16;
  localparam int WordsPerPage   = 64;
  localparam int CfgIdxW        = 3;

  localparam logic [1:0] OP_ERASE = 2'd0;
  localparam logic [1:0] OP_PROG  = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_W0_START = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_W0_END   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_W1_START = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_W1_END   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FILL     = 3'd4;

  localparam logic [1:0] COND_UNKNOWN    = 2'd0;
  localparam logic [1:0] COND_ERASED     = 2'd1;
  localparam logic [1:0] COND_PROGRAMMED = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] location;
    logic [6:0]  word_count;
    logic [31:0] data_in;
  } sfm_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic        is_data;
    logic        failed;
    logic        last;
  } sfm_out_t;
endpackage

// File: hdl/sector_flash_memory_model_top.sv
// Top level: sector and page flash store with windowed address decode.
//
// Commands enter on start while busy is low and each is worked on alone.
// Address lookup runs through a small sequencer that compares against one
// window per cycle (one 32-bit compare/subtract unit, reused). A data word
// is written to the word memory as it is taken, and its page mask is
// written back after it (a stray data word with nothing pending gets a
// failed status); every other command scans 1 to WINDOW_COUNT windows and
// then dispatches, where a rejected command or a program command ends; an
// erase then clears the sector's 16 page masks (one mask per cycle on the
// mask memory port); a read fetches the page mask and then gives one word
// per cycle (a read of count zero ends at dispatch). Mask and word
// memories are read with a registered port.
// Results show for one cycle on out_valid; the receiver cannot stall.
// After reset a clearing pass walks the page mask memory, one page per
// cycle; busy stays high meanwhile; configuration writes are taken at any
// time but belong between items.
module sector_flash_memory_model_top #(
  parameter int SECTOR_COUNT = sfm_pkg::DefSectorCount,
  parameter int WINDOW_COUNT = sfm_pkg::DefWindowCount
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sfm_pkg::sfm_in_t          in_item,
  output logic                      out_valid,
  output sfm_pkg::sfm_out_t         out_item,
  input  logic                      cfg_we,
  input  logic [sfm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import sfm_pkg::*;

  localparam int Pages  = SECTOR_COUNT * PagesPerSector;
  localparam int SecW   = (SECTOR_COUNT > 1) ? $clog2(SECTOR_COUNT) : 1;
  localparam int PageW  = SecW + 4;
  localparam int WordW  = PageW + 6;
  localparam int WinW   = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LOOK = 4'd2,
                         S_DISP = 4'd3, S_ERASE = 4'd4, S_RDREQ = 4'd5,
                         S_RDOUT = 4'd6;

  // configuration
  logic [31:0] win_start [2];
  logic [31:0] win_end   [2];
  logic [31:0] unknown_fill;

  // stores
  logic [1:0]  sector_condition [SECTOR_COUNT];
  logic [63:0] mask_mem [Pages];
  logic [31:0] word_mem [Pages*WordsPerPage];

  logic [3:0]       state;
  sfm_in_t          cmd;
  logic [31:0]      addr;
  logic [WinW-1:0]  win;
  logic [32:0]      base;
  logic             miss;
  logic [SecW-1:0]  sec;
  logic [31:0]      rel;
  logic [PageW-1:0] cnt_page;
  logic [5:0]       cnt_off;
  logic [PageW:0]   clr_cnt;
  logic [3:0]       erase_idx;
  logic [PageW-1:0] pend_page;
  logic [5:0]       pend_off;
  logic [6:0]       pend_rem;
  logic [6:0]       rd_i, rd_cnt;
  logic [63:0]      mask_rd;
  logic [31:0]      word_rd;
  logic [1:0]       rd_cond;
  logic [6:0]       rd_pos_q;

  // shared lookup unit: one window per cycle
  logic        w_en;
  logic [32:0] w_n, w_off, s_abs;
  logic [31:0] w_rel;
  always_comb begin
    w_en  = win_end[win] >= win_start[win];
    w_n   = ({1'b0, win_end[win]} - {1'b0, win_start[win]} + 33'd1) >> 12;
    w_rel = addr - win_start[win];
    w_off = {13'd0, w_rel[31:12]};
    s_abs = w_off + base;
  end

  wire [5:0] offset = rel[7:2];
  wire [PageW-1:0] page = {sec, rel[11:8]};
  wire [8:0] span = {1'b0, rel[7:0]} + {cmd.word_count, 2'b00} - 9'd1;

  assign busy = (state != S_IDLE);

  // memory port signals
  logic             mw_en, ww_en;
  logic [PageW-1:0] mw_addr;
  logic [63:0]      mw_data;
  logic [WordW-1:0] ww_addr;
  logic [31:0]      ww_data;
  logic             mr_en;
  logic [PageW-1:0] mr_addr;
  logic [WordW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (mw_en) mask_mem[mw_addr] <= mw_data;
    if (mr_en) mask_rd <= mask_mem[mr_addr];
  end
  always_ff @(posedge clk) begin
    if (ww_en) word_mem[ww_addr] <= ww_data;
    word_rd <= word_mem[wr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start[0] <= 32'd0;  win_end[0] <= 32'd65535;
      win_start[1] <= 32'd1;  win_end[1] <= 32'd0;
      unknown_fill <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_W0_START: win_start[0] <= cfg_data;
        REG_W0_END:   win_end[0]   <= cfg_data;
        REG_W1_START: win_start[1] <= cfg_data;
        REG_W1_END:   win_end[1]   <= cfg_data;
        REG_FILL:     unknown_fill <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory port steering
  always_comb begin
    mw_en = 1'b0; mw_addr = pend_page; mw_data = 64'd0;
    ww_en = 1'b0; ww_addr = {pend_page, pend_off}; ww_data = in_item.data_in;
    mr_en = 1'b0; mr_addr = pend_page;
    wr_addr = {page, offset + rd_i[5:0]};
    if (state == S_CLEAR) begin
      mw_en = 1'b1; mw_addr = clr_cnt[PageW-1:0];
    end else if (state == S_ERASE) begin
      mw_en = 1'b1; mw_addr = {sec, erase_idx};
    end else if (state == S_IDLE && start && in_item.opcode == OP_DATA
                 && pend_rem != 7'd0) begin
      ww_en = 1'b1;
      mr_en = 1'b0;
    end else if (state == S_RDREQ) begin
      mr_en = 1'b1; mr_addr = page;
    end
    // read-modify-write of the mask for a data word: the mask is fetched as
    // the word is taken and written back with the word's bit on the next cycle
    if (state == S_LOOK && cmd.opcode == OP_DATA) begin
      mw_en = 1'b1; mw_addr = cnt_page; mw_data = mask_rd | (64'd1 << cnt_off);
    end
    if (state == S_IDLE && start && in_item.opcode == OP_DATA) begin
      mr_en = 1'b1; mr_addr = pend_page;
    end
  end

  always_ff @(posedge clk) begin : seq_proc
    logic     out_valid_next;
    sfm_out_t out_item_next;
    out_valid_next = 1'b0;
    out_item_next  = '0;
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      pend_rem <= 7'd0; pend_page <= '0; pend_off <= 6'd0;
      for (int k = 0; k < SECTOR_COUNT; k++) sector_condition[k] <= COND_UNKNOWN;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (PageW+1)'(Pages - 1)) state <= S_IDLE;
        end
        S_IDLE: if (start) begin
          cmd <= in_item;
          win <= '0; base <= '0; miss <= 1'b0;
          addr <= (in_item.opcode == OP_ERASE) ? {in_item.location[19:0], 12'd0}
                                               : in_item.location;
          if (in_item.opcode == OP_DATA) begin
            if (pend_rem == 7'd0) begin
              out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b1, 1'b1};
              state <= S_IDLE;
            end else begin
              cnt_page <= pend_page;
              cnt_off <= pend_off;
              sector_condition[pend_page[PageW-1:4]] <= COND_PROGRAMMED;
              pend_off <= pend_off + 6'd1;
              pend_rem <= pend_rem - 7'd1;
              if (pend_rem == 7'd1) begin
                out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b0, 1'b1};
              end
              state <= S_LOOK;
            end
          end else begin
            pend_rem <= 7'd0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (cmd.opcode == OP_DATA) begin
            state <= S_IDLE;  // mask write done this cycle
          end else if (!w_en) begin
            if (int'(win) == WINDOW_COUNT - 1) begin miss <= 1'b1; state <= S_DISP; end
            else win <= win + 1'b1;
          end else if (addr < win_start[win]) begin
            miss <= 1'b1; state <= S_DISP;
          end else if (addr <= win_end[win]) begin
            rel <= w_rel;
            sec <= s_abs[SecW-1:0];
            miss <= (w_off >= w_n) || (s_abs >= 33'(SECTOR_COUNT));
            state <= S_DISP;
          end else begin
            base <= base + w_n;
            if (int'(win) == WINDOW_COUNT - 1) begin miss <= 1'b1; state <= S_DISP; end
            else win <= win + 1'b1;
          end
        end
        S_DISP: begin
          if (miss) begin
            out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b1, 1'b1};
            state <= S_IDLE;
          end else begin
            unique case (cmd.opcode)
              OP_ERASE: begin
                sector_condition[sec] <= COND_ERASED;
                erase_idx <= 4'd0; state <= S_ERASE;
              end
              OP_PROG: begin
                if (sector_condition[sec] == COND_UNKNOWN || cmd.word_count == 7'd0
                    || cmd.word_count > 7'd64 || span[8]) begin
                  out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b1, 1'b1};
                end else begin
                  pend_page <= page; pend_off <= offset; pend_rem <= cmd.word_count;
                end
                state <= S_IDLE;
              end
              default: begin
                rd_cnt <= (cmd.word_count > 7'd64) ? 7'd64 : cmd.word_count;
                rd_i <= 7'd0; rd_cond <= sector_condition[sec];
                if (cmd.word_count == 7'd0) begin
                  out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b0, 1'b1};
                  state <= S_IDLE;
                end else state <= S_RDREQ;
              end
            endcase
          end
        end
        S_ERASE: begin
          erase_idx <= erase_idx + 4'd1;
          if (erase_idx == 4'd15) begin
            out_valid_next = 1'b1; out_item_next = '{32'd0, 1'b0, 1'b0, 1'b1};
            state <= S_IDLE;
          end
        end
        S_RDREQ: begin
          rd_pos_q <= {1'b0, offset};
          rd_i <= rd_i + 7'd1;
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          // word_rd holds position rd_pos_q
          out_valid_next = 1'b1;
          out_item_next.is_data = 1'b1;
          out_item_next.last = (rd_i == rd_cnt);
          if (rd_cond == COND_UNKNOWN) out_item_next.data_out = unknown_fill;
          else if (rd_cond == COND_ERASED || rd_pos_q >= 7'd64) out_item_next.data_out = '1;
          else if (mask_rd[rd_pos_q[5:0]]) out_item_next.data_out = word_rd;
          else out_item_next.data_out = '1;
          rd_pos_q <= rd_pos_q + 7'd1;
          rd_i <= rd_i + 7'd1;
          if (rd_i == rd_cnt) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
    out_valid <= out_valid_next;
    out_item  <= out_item_next;
  end
  // word read address follows the position being fetched
  // (rd_i counts words already requested; read data arrives in the next cycle)
endmodule

// File: hdl/sfm_checker.sv
// Port-level checker for the sector flash store, bound to the top level.
`include "assert_macros.svh"
module sfm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic out_valid,
  input sfm_pkg::sfm_out_t out_item
);
  import sfm_pkg::*;
  `CHECK_IMPLY(a_status_last, clk, rst, out_valid && !out_item.is_data, out_item.last, "status not last")
  `CHECK_IMPLY(a_fail_nodata, clk, rst, out_valid && out_item.failed, !out_item.is_data, "failed with data")
  `CHECK_IMPLY(a_zero_status, clk, rst, out_valid && !out_item.is_data, out_item.data_out == 32'd0, "status data nonzero")
  `CHECK_NEXT(a_take_busy, clk, rst, start && !busy && !out_valid, busy || out_valid, "item vanished")
endmodule

bind sector_flash_memory_model_top sfm_checker u_sfm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
